### rtl/core/optt_pkg.sv
// shared types and constants for the timer table
package optt_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned IdW          = 32;
  localparam int unsigned MsW          = 32;
  localparam int unsigned SecsW        = 23;
  localparam int unsigned MsPerSecond  = 1000;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_KILL     = 2'd1,
    OP_KILL_ALL = 2'd2,
    OP_CHECK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ADDED    = 2'd1,
    EV_REJECTED = 2'd2,
    EV_FIRED    = 2'd3
  } event_t;

  // one table entry as handed between neighboring cells
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic             periodic;
    logic [MsW-1:0]   timeout_ms;
    logic [MsW-1:0]   start_ms;
  } entry_t;

  // broadcast to all cells while flags are evaluated
  typedef struct packed {
    logic           eval_en;
    logic           is_kill;
    logic [IdW-1:0] target;
    logic [MsW-1:0] now_ms;
  } eval_ctl_t;

  // broadcast to all cells when the operation is applied
  typedef struct packed {
    logic           add_en;
    logic           kill_all;
    logic           pick_en;
    logic           is_kill;
    logic [MsW-1:0] now_ms;
    entry_t         new_entry;
  } commit_ctl_t;

endpackage

### rtl/core/oneshot_periodic_timer_table.sv
// top level of the one-shot and periodic timer table
// Each operation passes ST_IDLE, ST_EVAL and ST_COMMIT: the transfer is captured, every
// cell then evaluates its own match or expiry flag (and the seconds-to-ms multiply runs),
// and in ST_COMMIT, which waits while the output register holds an untaken result, the
// first hit is picked along the cell chain and the table adds, shifts, clears or restarts.
// A new input transfer is taken once the previous operation is applied, even while its
// result waits on the output register, but not before. The table keeps insertion order
// in SLOTS cells; kill-all and the id counter keep the pending immediate timer apart.
module oneshot_periodic_timer_table #(
  parameter int unsigned SLOTS = optt_pkg::SlotsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // operation[1:0], timeout_seconds[24:2], periodic[25], target_id[57:26], now_ms[89:58]
  input  logic [optt_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // event_res[1:0], timer_id[33:2]
  output logic [optt_pkg::OutDataW-1:0] out_tdata
);
  import optt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  op_t              op_r;
  logic [SecsW-1:0] secs_r;
  logic             per_r;
  logic [IdW-1:0]   target_r;
  logic [MsW-1:0]   now_r;
  logic [MsW-1:0]   tmo_ms_r;
  logic [IdW-1:0]   next_id_r;
  logic [IdW-1:0]   imm_r;
  logic             out_valid_r;
  event_t           out_ev_r;
  logic [IdW-1:0]   out_id_r;

  logic             in_xfer;
  logic             commit_go;
  logic [MsW:0]     tmo_prod;
  logic [IdW-1:0]   new_id;
  logic             full;
  logic             imm_add;
  logic             imm_fire;
  event_t           ev_nxt;
  logic [IdW-1:0]   id_nxt;

  eval_ctl_t        ev_ctl;
  commit_ctl_t      cm_ctl;

  entry_t           ent   [SLOTS+1];
  logic             hit_c [SLOTS+1];
  logic             sh_c  [SLOTS+1];
  logic [IdW-1:0]   id_c  [SLOTS+1];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign commit_go  = (state_r == ST_COMMIT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - IdW - 2){1'b0}}, out_id_r, out_ev_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = ST_COMMIT;
      ST_COMMIT: if (commit_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= op_t'(in_tdata[1:0]);
      secs_r   <= in_tdata[24:2];
      per_r    <= in_tdata[25];
      target_r <= in_tdata[57:26];
      now_r    <= in_tdata[89:58];
    end
  end

  // seconds to ms, saturated to 32 bits
  assign tmo_prod = (MsW+1)'(secs_r) * (MsW+1)'(MsPerSecond);
  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      tmo_ms_r <= tmo_prod[MsW] ? {MsW{1'b1}} : tmo_prod[MsW-1:0];
    end
  end

  // operation decode
  assign new_id   = (next_id_r == {IdW{1'b1}}) ? IdW'(1) : next_id_r + IdW'(1);
  assign full     = ent[SLOTS-1].valid;
  assign imm_add  = (op_r == OP_ADD) && (secs_r == '0) && (imm_r == '0);
  assign imm_fire = (op_r == OP_CHECK) && (imm_r != '0);

  assign ev_ctl.eval_en = (state_r == ST_EVAL);
  assign ev_ctl.is_kill = (op_r == OP_KILL);
  assign ev_ctl.target  = target_r;
  assign ev_ctl.now_ms  = now_r;

  assign cm_ctl.add_en   = commit_go && (op_r == OP_ADD) && !imm_add && !full;
  assign cm_ctl.kill_all = commit_go && (op_r == OP_KILL_ALL);
  assign cm_ctl.pick_en  = commit_go && (((op_r == OP_KILL) && (target_r != '0)) ||
                                         ((op_r == OP_CHECK) && !imm_fire));
  assign cm_ctl.is_kill  = (op_r == OP_KILL);
  assign cm_ctl.now_ms   = now_r;
  assign cm_ctl.new_entry = '{valid: 1'b1, id: new_id, periodic: per_r,
                              timeout_ms: tmo_ms_r, start_ms: now_r};

  // chain ends
  assign ent[SLOTS]   = '0;
  assign hit_c[0]     = 1'b0;
  assign sh_c[0]      = 1'b0;
  assign id_c[0]      = '0;

  // row of cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic pv;
    if (g == 0) begin : g_head
      assign pv = 1'b1;
    end else begin : g_body
      assign pv = ent[g-1].valid;
    end
    optt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ev_ctl     (ev_ctl),
      .cm_ctl     (cm_ctl),
      .prev_valid (pv),
      .nb_entry   (ent[g+1]),
      .own_entry  (ent[g]),
      .hit_in     (hit_c[g]),
      .hit_out    (hit_c[g+1]),
      .shift_in   (sh_c[g]),
      .shift_out  (sh_c[g+1]),
      .id_in      (id_c[g]),
      .id_out     (id_c[g+1])
    );
  end

  // result of the operation
  always_comb begin
    ev_nxt = EV_NONE;
    id_nxt = '0;
    case (op_r)
      OP_ADD: begin
        if (imm_add || !full) begin
          ev_nxt = EV_ADDED;
          id_nxt = new_id;
        end else begin
          ev_nxt = EV_REJECTED;
        end
      end
      OP_CHECK: begin
        if (imm_fire) begin
          ev_nxt = EV_FIRED;
          id_nxt = imm_r;
        end else if (hit_c[SLOTS]) begin
          ev_nxt = EV_FIRED;
          id_nxt = id_c[SLOTS];
        end
      end
      default: begin
        ev_nxt = EV_NONE;
        id_nxt = '0;
      end
    endcase
  end

  // id counter and immediate timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= '0;
      imm_r     <= '0;
    end else if (commit_go) begin
      if (imm_add || cm_ctl.add_en) begin
        next_id_r <= new_id;
      end
      if (imm_add) begin
        imm_r <= new_id;
      end else if (imm_fire) begin
        imm_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_ev_r <= ev_nxt;
      out_id_r <= id_nxt;
    end
  end

  // checks
  a_none_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ev_r == EV_NONE || out_ev_r == EV_REJECTED)) |-> (out_id_r == '0))
    else $error("no-event result carries an id");

  a_added_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && ev_nxt == EV_ADDED) |=> (next_id_r != '0 && out_id_r == next_id_r))
    else $error("added id does not match the id counter");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && ev_nxt == EV_REJECTED) |-> full)
    else $error("add rejected while the table has room");

  a_fire_clears_imm: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && imm_fire) |=> (imm_r == '0))
    else $error("immediate timer still pending after firing");

endmodule

### rtl/core/optt_cell.sv
// one slot of the timer table chain
module optt_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  optt_pkg::eval_ctl_t   ev_ctl,
  input  optt_pkg::commit_ctl_t cm_ctl,
  input  logic                  prev_valid,
  input  optt_pkg::entry_t      nb_entry,
  output optt_pkg::entry_t      own_entry,
  input  logic                  hit_in,
  output logic                  hit_out,
  input  logic                  shift_in,
  output logic                  shift_out,
  input  logic [31:0]           id_in,
  output logic [31:0]           id_out
);
  import optt_pkg::*;

  logic           valid_r;
  logic [IdW-1:0] id_r;
  logic           per_r;
  logic [MsW-1:0] tmo_r;
  logic [MsW-1:0] start_r;
  logic           hit_r;

  logic           hit_nxt;
  logic [MsW-1:0] elapsed;
  logic           sel;
  logic           rm_here;
  logic           shift;
  logic           ins;

  assign own_entry = '{valid: valid_r, id: id_r, periodic: per_r,
                       timeout_ms: tmo_r, start_ms: start_r};

  // local match or expiry flag
  assign elapsed = ev_ctl.now_ms - start_r;
  always_comb begin
    if (ev_ctl.is_kill) begin
      hit_nxt = valid_r && (id_r == ev_ctl.target);
    end else begin
      hit_nxt = valid_r && (elapsed >= tmo_r);
    end
  end

  // first-hit selection and shift chain
  assign sel       = cm_ctl.pick_en && hit_r && !hit_in;
  assign hit_out   = hit_in || (cm_ctl.pick_en && hit_r);
  assign rm_here   = sel && (cm_ctl.is_kill || !per_r);
  assign shift     = shift_in || rm_here;
  assign shift_out = shift;
  assign id_out    = sel ? id_r : id_in;
  assign ins       = !valid_r && prev_valid;

  // flag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ev_ctl.eval_en) begin
      hit_r <= hit_nxt;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cm_ctl.kill_all) begin
      valid_r <= 1'b0;
    end else if (cm_ctl.add_en && ins) begin
      valid_r <= 1'b1;
    end else if (shift) begin
      valid_r <= nb_entry.valid;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (!cm_ctl.kill_all && cm_ctl.add_en && ins) begin
      id_r    <= cm_ctl.new_entry.id;
      per_r   <= cm_ctl.new_entry.periodic;
      tmo_r   <= cm_ctl.new_entry.timeout_ms;
      start_r <= cm_ctl.new_entry.start_ms;
    end else if (!cm_ctl.kill_all && shift) begin
      id_r    <= nb_entry.id;
      per_r   <= nb_entry.periodic;
      tmo_r   <= nb_entry.timeout_ms;
      start_r <= nb_entry.start_ms;
    end else if (!cm_ctl.kill_all && sel) begin
      start_r <= cm_ctl.now_ms;
    end
  end

endmodule

### verif/oneshot_periodic_timer_table_checker.sv
// transfer monitor, timer table predictor and result comparison
`timescale 1ns / 100ps

module oneshot_periodic_timer_table_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // operation[1:0], timeout_seconds[24:2], periodic[25], target_id[57:26], now_ms[89:58]
  input  logic [optt_pkg::InDataW-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // event_res[1:0], timer_id[33:2]
  input  logic [optt_pkg::OutDataW-1:0] out_tdata,
  output int                            errors,
  output int                            pending,
  output int                            n_ops,
  output int                            n_results,
  output int                            n_fired,
  output int                            n_rejected
);
  import optt_pkg::*;

  localparam int Slots = SlotsDefault;

  typedef struct packed {
    event_t         ev;
    logic [IdW-1:0] id;
  } timer_result_t;

  // predicted table, kept in insertion order in entries 0..used-1
  logic [IdW-1:0] last_id;
  logic [IdW-1:0] imm_id;
  int             used;
  logic [IdW-1:0] tab_id    [Slots];
  logic           tab_per   [Slots];
  logic [MsW-1:0] tab_tmo   [Slots];
  logic [MsW-1:0] tab_start [Slots];

  timer_result_t  expected_events [$];

  // next nonzero id, skipping zero on wrap
  function automatic logic [IdW-1:0] take_id();
    last_id = (last_id == '1) ? IdW'(1) : last_id + IdW'(1);
    return last_id;
  endfunction

  // remove one entry and close the gap
  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < used; i++) begin
      tab_id[i]    = tab_id[i+1];
      tab_per[i]   = tab_per[i+1];
      tab_tmo[i]   = tab_tmo[i+1];
      tab_start[i] = tab_start[i+1];
    end
    used--;
  endfunction

  task automatic predict_timer_op(input op_t op, input logic [SecsW-1:0] secs,
                                  input logic per, input logic [IdW-1:0] target,
                                  input logic [MsW-1:0] now, output timer_result_t res);
    logic [63:0]    ms;
    logic [MsW-1:0] elapsed;
    int             hit;
    res.ev = EV_NONE;
    res.id = '0;
    hit    = -1;
    case (op)
      OP_ADD: begin
        if (secs == '0 && imm_id == '0) begin
          imm_id = take_id();
          res.ev = EV_ADDED;
          res.id = imm_id;
        end else if (used >= Slots) begin
          res.ev = EV_REJECTED;
        end else begin
          // timeout in ms saturates at 32 bits
          ms = 64'(secs) * 64'(MsPerSecond);
          if (ms > 64'hFFFF_FFFF) ms = 64'hFFFF_FFFF;
          res.ev          = EV_ADDED;
          res.id          = take_id();
          tab_id[used]    = res.id;
          tab_per[used]   = per;
          tab_tmo[used]   = ms[MsW-1:0];
          tab_start[used] = now;
          used++;
        end
      end
      OP_KILL: begin
        // first match only, immediate timer untouched
        if (target != '0) begin
          for (int i = 0; i < used; i++)
            if (hit < 0 && tab_id[i] == target) hit = i;
          if (hit >= 0) drop_slot(hit);
        end
      end
      OP_KILL_ALL: begin
        used = 0;
      end
      default: begin
        if (imm_id != '0) begin
          res.ev = EV_FIRED;
          res.id = imm_id;
          imm_id = '0;
        end else begin
          for (int i = 0; i < used; i++) begin
            elapsed = now - tab_start[i];
            if (hit < 0 && elapsed >= tab_tmo[i]) hit = i;
          end
          if (hit >= 0) begin
            res.ev = EV_FIRED;
            res.id = tab_id[hit];
            if (tab_per[hit]) tab_start[hit] = now;
            else drop_slot(hit);
          end
        end
      end
    endcase
  endtask

  // results are taken before inputs so a same-edge input never pairs with a result
  always @(posedge clk) begin
    timer_result_t want;
    timer_result_t got;
    if (!rst_n) begin
      last_id = '0;
      imm_id  = '0;
      used    = 0;
      expected_events.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        got.ev = event_t'(out_tdata[1:0]);
        got.id = out_tdata[33:2];
        if (expected_events.size() == 0) begin
          $error("unexpected result transfer: event_res %0d timer_id %0d", got.ev, got.id);
          errors++;
        end else begin
          want = expected_events.pop_front();
          if (want.ev == EV_FIRED) n_fired++;
          if (want.ev == EV_REJECTED) n_rejected++;
          if (got.ev !== want.ev) begin
            $error("event_res mismatch: expected %0d, actual %0d", want.ev, got.ev);
            errors++;
          end
          if (got.id !== want.id) begin
            $error("timer_id mismatch: expected %0d, actual %0d", want.id, got.id);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_ops++;
        predict_timer_op(op_t'(in_tdata[1:0]), in_tdata[24:2], in_tdata[25],
                         in_tdata[57:26], in_tdata[89:58], want);
        expected_events.insert(expected_events.size(), want);
      end
    end
    pending = expected_events.size();
  end

endmodule

### verif/oneshot_periodic_timer_table_tb.sv
// stimulus, handshake pacing and verdict for the timer table
`timescale 1ns / 100ps

module oneshot_periodic_timer_table_tb;
  import optt_pkg::*;

  localparam int RandomOps = 700;
  localparam int CalmOps   = 100;
  localparam int CycleLimit = 200000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // operation[1:0], timeout_seconds[24:2], periodic[25], target_id[57:26], now_ms[89:58]
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // event_res[1:0], timer_id[33:2]
  logic [OutDataW-1:0] out_tdata;

  int errors, pending, n_ops, n_results, n_fired, n_rejected;
  int cycles;
  bit idle_on;
  int adds_sent;
  logic [MsW-1:0] now_cur;

  always #6 clk = ~clk;

  oneshot_periodic_timer_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  oneshot_periodic_timer_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending),
    .n_ops      (n_ops),
    .n_results  (n_results),
    .n_fired    (n_fired),
    .n_rejected (n_rejected)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side stalls in short bursts
  always begin
    @(posedge clk);
    if (rst_n && idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  // pack one operation and hold it until the transfer
  task automatic send_op(input op_t op, input logic [SecsW-1:0] secs, input logic per,
                         input logic [IdW-1:0] target, input logic [MsW-1:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    if (op == OP_ADD) adds_sent++;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, now, target, per, secs, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int roll;
    int lo;
    logic [SecsW-1:0] secs;
    logic [IdW-1:0]   target;
    idle_on   = 1'b1;
    adds_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, immediate timer, zero timeout in table, saturation
    send_op(OP_CHECK, '0, 1'b0, '0, 32'd100);
    send_op(OP_KILL, '0, 1'b0, '0, 32'd100);
    send_op(OP_ADD, '0, 1'b0, '0, 32'd200);
    send_op(OP_ADD, '0, 1'b1, '0, 32'd300);
    send_op(OP_ADD, '1, 1'b0, '0, 32'd400);
    // kill-all keeps the pending immediate timer
    send_op(OP_KILL_ALL, '0, 1'b0, '0, 32'd500);
    send_op(OP_CHECK, '0, 1'b0, '0, 32'd600);
    // elapsed time across the 32-bit wrap
    send_op(OP_ADD, 23'd1, 1'b1, '0, 32'hFFFF_FC00);
    send_op(OP_CHECK, '0, 1'b0, '0, 32'h0000_01F0);
    send_op(OP_KILL, '0, 1'b0, '1, 32'h0000_0200);
    send_op(OP_KILL, '0, 1'b0, 32'd4, 32'h0000_0200);
    // fill the table, one more add is rejected
    for (int i = 0; i < 17; i++)
      send_op(OP_ADD, 23'd100, 1'(i), '0, 32'd1000 + i);
    // immediate still accepted with a full table, a second zero timeout is not
    send_op(OP_ADD, '0, 1'b0, '0, 32'd1100);
    send_op(OP_ADD, '0, 1'b1, '0, 32'd1100);
    send_op(OP_KILL, '0, 1'b0, 32'd10, 32'd1200);
    send_op(OP_CHECK, '0, 1'b0, '0, 32'd1300);
    send_op(OP_CHECK, '0, 1'b0, '0, 32'd1400);

    // random: mostly a steadily advancing clock with short timeouts
    now_cur = 32'd5000;
    for (int n = 0; n < RandomOps; n++) begin
      if (n == RandomOps - CalmOps) idle_on = 1'b0;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) now_cur = $urandom;
      else now_cur = now_cur + $urandom_range(0, 1500);
      if (roll < 7) begin
        // noise: every field random
        send_op(op_t'($urandom_range(0, 3)), SecsW'($urandom), 1'($urandom), $urandom,
                $urandom);
      end else if (roll < 42) begin
        case ($urandom_range(0, 19))
          0, 1:    secs = '0;
          2:       secs = SecsW'($urandom);
          default: secs = SecsW'($urandom_range(1, 4));
        endcase
        send_op(OP_ADD, secs, 1'($urandom), '0, now_cur);
      end else if (roll < 77) begin
        send_op(OP_CHECK, '0, 1'b0, '0, now_cur);
      end else if (roll < 97) begin
        lo = (adds_sent > 20) ? adds_sent - 20 : 1;
        case ($urandom_range(0, 6))
          0:       target = '0;
          1:       target = $urandom;
          default: target = IdW'($urandom_range(lo, adds_sent + 1));
        endcase
        send_op(OP_KILL, '0, 1'b0, target, now_cur);
      end else begin
        send_op(OP_KILL_ALL, '0, 1'b0, '0, now_cur);
      end
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d operations over %0d cycles with %0d results checked",
             n_ops, cycles, n_results);
    $display("%0d timers fired and %0d adds rejected on a full table", n_fired, n_rejected);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
